@@ hw/rtl/uvd_pkg.sv @@
// Shared types, constants and lead-byte helpers for the UTF-8 validating decoder.
// No dependencies; compiled first.
package uvd_pkg;

  // Width of a decoded scalar value
  localparam int unsigned CP_W = 21;

  // Lead and continuation byte patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;

  // Range limits on scalar values
  localparam logic [CP_W-1:0] MIN2_CP   = 21'h000080;
  localparam logic [CP_W-1:0] MIN3_CP   = 21'h000800;
  localparam logic [CP_W-1:0] MIN4_CP   = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

  // Classification of a byte in lead position
  typedef enum logic [2:0] {
    LK_ASCII,
    LK_TWO,
    LK_THREE,
    LK_FOUR,
    LK_BAD
  } lead_kind_t;

  // One result item
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_valid;
    logic [2:0]      bytes_used;
    logic            run_last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic sel_input;  // decode the buffer with the incoming byte appended
    logic advance;    // update the buffer from the decode view
    logic consume;    // drop the decoded bytes and load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result; // the buffer front yields a result now
    logic run_last;   // that result is the final one for this byte
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

  function automatic lead_kind_t lead_kind(input logic [7:0] b);
    lead_kind_t k;
    if (!b[7]) begin
      k = LK_ASCII;
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      k = LK_TWO;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      k = LK_THREE;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      k = LK_FOUR;
    end else begin
      k = LK_BAD;
    end
    return k;
  endfunction

  // Bytes a lead needs before it can be judged
  function automatic logic [2:0] seq_len(input lead_kind_t k);
    logic [2:0] n;
    unique case (k)
      LK_TWO:   n = 3'd2;
      LK_THREE: n = 3'd3;
      LK_FOUR:  n = 3'd4;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_PAT;
  endfunction

endpackage

@@ hw/rtl/uvd_byte_if.sv @@
// Byte channel into the UTF-8 decoder: valid/ready plus one stream byte.
// No dependencies.
interface uvd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

@@ hw/rtl/uvd_code_if.sv @@
// Result channel out of the UTF-8 decoder: valid/ready plus one decoded result.
// No dependencies.
interface uvd_code_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        is_valid;
  logic [2:0]  bytes_used;
  logic        run_last;

  modport source (output valid, code_point, is_valid, bytes_used, run_last, input ready);
  modport sink   (input valid, code_point, is_valid, bytes_used, run_last, output ready);
endinterface

@@ hw/rtl/uvd_datapath.sv @@
// Datapath of the UTF-8 decoder: pending byte buffer, front decoder, output register.
// Depends on uvd_pkg.
module uvd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         in_byte,
  input  logic               in_eoi,
  input  logic               out_ready,
  input  uvd_pkg::dp_cmd_t   cmd,
  output uvd_pkg::dp_status_t st,
  output logic               out_valid,
  output uvd_pkg::out_item_t out_item
);
  import uvd_pkg::*;

  logic [7:0] pend [0:3];
  logic [2:0] count;
  logic       eoi_q;

  logic [7:0] view [0:3];
  logic [2:0] view_count;
  logic       view_eoi;

  logic [7:0]      shifted [0:3];
  logic [2:0]      rem;
  logic            has_result;
  logic [CP_W-1:0] res_cp;
  logic            res_valid;
  logic [2:0]      res_used;
  logic            next_stop;

  // Decode view: buffer alone, or buffer with the incoming byte appended
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      view[i] = (cmd.sel_input && count == 3'(i)) ? in_byte : pend[i];
    end
    view_count = cmd.sel_input ? count + 3'd1 : count;
    view_eoi   = cmd.sel_input ? in_eoi : eoi_q;
  end

  // Decode the sequence at the buffer front
  always_comb begin
    lead_kind_t      kind;
    logic [2:0]      need;
    logic            c1, c2, c3;
    logic [CP_W-1:0] v2, v3, v4;
    logic            ok2, ok3, ok4;

    kind = lead_kind(view[0]);
    need = seq_len(kind);
    c1   = is_cont(view[1]);
    c2   = is_cont(view[2]);
    c3   = is_cont(view[3]);
    v2   = CP_W'({view[0][4:0], view[1][5:0]});
    v3   = CP_W'({view[0][3:0], view[1][5:0], view[2][5:0]});
    v4   = {view[0][2:0], view[1][5:0], view[2][5:0], view[3][5:0]};
    ok2  = c1 && v2 >= MIN2_CP;
    ok3  = c1 && c2 && v3 >= MIN3_CP && !(v3 >= SURR_LO && v3 <= SURR_HI);
    ok4  = c1 && c2 && c3 && v4 >= MIN4_CP && v4 <= MAX_CP;

    // rejected lead by default: raw byte, one byte consumed
    has_result = 1'b1;
    res_cp     = CP_W'(view[0]);
    res_valid  = 1'b0;
    res_used   = 3'd1;

    if (view_count == 3'd0) begin
      has_result = 1'b0;
    end else begin
      unique case (kind)
        LK_ASCII: res_valid = 1'b1;
        LK_BAD:   res_valid = 1'b0;
        default: begin
          if (need > view_count) begin
            // incomplete: wait, or flush the lead at end of input
            has_result = view_eoi;
          end else begin
            unique case (kind)
              LK_TWO: if (ok2) begin
                res_valid = 1'b1;
                res_cp    = v2;
                res_used  = 3'd2;
              end
              LK_THREE: if (ok3) begin
                res_valid = 1'b1;
                res_cp    = v3;
                res_used  = 3'd3;
              end
              LK_FOUR: if (ok4) begin
                res_valid = 1'b1;
                res_cp    = v4;
                res_used  = 3'd4;
              end
              default: res_valid = 1'b0;
            endcase
          end
        end
      endcase
    end
  end

  // Buffer after dropping the consumed bytes
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shifted[i] = view[i];
    end
    case (res_used)
      3'd1: begin
        shifted[0] = view[1];
        shifted[1] = view[2];
        shifted[2] = view[3];
      end
      3'd2: begin
        shifted[0] = view[2];
        shifted[1] = view[3];
      end
      3'd3: shifted[0] = view[3];
      default: ;
    endcase
    rem = view_count - res_used;
  end

  // Last result for this byte: buffer empties, or the next lead must wait
  assign next_stop = (rem == 3'd0) ||
                     (!view_eoi && seq_len(lead_kind(shifted[0])) > rem);

  assign st.has_result = has_result;
  assign st.run_last   = next_stop;
  assign st.out_free   = !out_valid || out_ready;

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (cmd.advance) begin
      count <= cmd.consume ? rem : view_count;
    end
  end

  // Buffered bytes and end flag
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      for (int i = 0; i < 4; i++) begin
        pend[i] <= cmd.consume ? shifted[i] : view[i];
      end
      eoi_q <= view_eoi;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.consume) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.consume) begin
      out_item.code_point <= res_cp;
      out_item.is_valid   <= res_valid;
      out_item.bytes_used <= res_used;
      out_item.run_last   <= next_stop;
    end
  end

`ifndef ASSERT_OFF
  // at most three bytes stay pending between results
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd3)
    else $error("pending byte count above three");

  // the final result at end of input leaves the buffer empty
  a_eoi_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.consume && next_stop && view_eoi |=> count == 3'd0)
    else $error("bytes left pending after end of input");
`endif

endmodule

@@ hw/rtl/uvd_ctrl.sv @@
// Controller of the UTF-8 decoder: accepts bytes and sequences the result drain.
// Depends on uvd_pkg.
module uvd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  uvd_pkg::dp_status_t st,
  output uvd_pkg::dp_cmd_t    cmd
);
  import uvd_pkg::*;

  typedef enum logic {
    ST_ACCEPT,
    ST_DRAIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Commands and next state
  always_comb begin
    in_ready      = (state == ST_ACCEPT) && st.out_free;
    accept        = in_valid && in_ready;
    cmd.sel_input = (state == ST_ACCEPT);
    cmd.consume   = 1'b0;
    cmd.advance   = 1'b0;
    state_next    = state;
    unique case (state)
      ST_ACCEPT: begin
        cmd.advance = accept;
        cmd.consume = accept && st.has_result;
        if (accept && st.has_result && !st.run_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.consume = st.has_result && st.out_free;
        cmd.advance = cmd.consume;
        if (!st.has_result || (cmd.consume && st.run_last)) begin
          state_next = ST_ACCEPT;
        end
      end
      default: state_next = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  // draining only happens while the buffer front still decodes to a result
  a_drain_has_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> st.has_result)
    else $error("drain state without a pending result");

  // a result never overwrites one still waiting in the output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.consume |-> st.out_free)
    else $error("result loaded into a full output register");

  // a result that is not the last one keeps the drain going
  a_drain_continues: assert property (@(posedge clk) disable iff (rst)
    cmd.consume && !st.run_last |=> state == ST_DRAIN)
    else $error("left drain before the last result");
`endif

endmodule

@@ hw/rtl/utf8_validating_decoder_core.sv @@
// UTF-8 validating decoder, top level.
// Byte channel byte_stream (uvd_byte_if): one stream byte per transfer,
// end_of_input set on the final byte flushes whatever is still pending.
// Result channel code_stream (uvd_code_if): one scalar value per well-formed
// sequence; a rejected or truncated lead comes out as its raw byte with
// is_valid low and bytes_used 1, and the bytes after it are decoded afresh.
// run_last marks the final result caused by a byte; a byte that only
// extends an incomplete sequence causes no result.
// Throughput: a byte that yields several results is drained one at a time by
// the single front-of-buffer decoder, which judges one sequence per cycle
// while the output register can take a result.
// Latency: the first result sits in the output register the cycle after its
// byte transfers.
// Reset: the pending buffer is emptied and the output register is marked empty.
// Stall: the output register holds its result until taken; while it is full
// and not being taken, byte_stream.ready stays low, as it does while
// further results of the same byte are drained.
// Depends on uvd_pkg, uvd_byte_if, uvd_code_if, uvd_ctrl, uvd_datapath.
module utf8_validating_decoder_core (
  input  logic       clk,
  input  logic       rst,
  uvd_byte_if.sink   byte_stream,
  uvd_code_if.source code_stream
);
  import uvd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  out_item_t  out_item;
  logic       out_valid;
  logic       in_ready;

  uvd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_stream.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  uvd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (byte_stream.data_byte),
    .in_eoi    (byte_stream.end_of_input),
    .out_ready (code_stream.ready),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Channel wiring
  assign byte_stream.ready      = in_ready;
  assign code_stream.valid      = out_valid;
  assign code_stream.code_point = out_item.code_point;
  assign code_stream.is_valid   = out_item.is_valid;
  assign code_stream.bytes_used = out_item.bytes_used;
  assign code_stream.run_last   = out_item.run_last;

endmodule
